// ===== rtl/lruc_pkg.sv =====
// Shared constants and result codes for the LRU cache with expiry.
package lruc_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int KEY_W    = 64;
  localparam int DATA_W   = 32;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 5;
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_MISS      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HIT       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EVICTED   = 3'd5;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] diff;
    logic              borrow;
  } lruc_sub_t;

endpackage

// ===== rtl/lruc_alu.sv =====
// Shared 32-bit subtractor with borrow, used for elapsed time and remaining life.
module lruc_alu (
  input  logic [lruc_pkg::TIME_W-1:0] a,
  input  logic [lruc_pkg::TIME_W-1:0] b,
  output lruc_pkg::lruc_sub_t         res
);
  import lruc_pkg::*;

  logic [TIME_W:0] wide;

  assign wide       = {1'b0, a} - {1'b0, b};
  assign res.diff   = wide[TIME_W-1:0];
  assign res.borrow = wide[TIME_W];

endmodule

// ===== rtl/lru_cache_with_ttl_core.sv =====
// Fully associative LRU cache of keyed values with per-entry time to live.
//
// Input channel (in_valid / in_stall): one transaction is a lookup (opcode 0)
// or an insert (opcode 1) of lookup_key, with data_value, lifetime and the
// current time now_time. Output channel (out_valid / out_stall): one result
// per input transaction with status, hit_value and remaining_life.
// Each transaction passes the steps scan, elapse, live and apply: the key
// scan steps through every entry with the single key comparator, the shared
// subtractor then gives elapsed time, then remaining life and the expiry
// test, and the apply step updates recency and writes the output register.
// The inputs are captured at the accepting edge. in_stall is high from
// acceptance until that update; a new transaction is accepted only after it.
// The output register holds a finished result while the receiver stalls;
// the next transaction is still accepted and runs its scan, and waits in the
// update step only if the earlier result has not been taken by then. The user
// writes max_entries through cfg_we / cfg_data only while the block is idle;
// the block does not enforce this. Reset (rst, synchronous) empties the cache,
// sets max_entries to 16, drops any pending result; no clearing pass is needed.
module lru_cache_with_ttl_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lruc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [lruc_pkg::KEY_W-1:0]     lookup_key,
  input  logic [lruc_pkg::DATA_W-1:0]    data_value,
  input  logic [lruc_pkg::TIME_W-1:0]    lifetime,
  input  logic [lruc_pkg::TIME_W-1:0]    now_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lruc_pkg::STATUS_W-1:0]  status,
  output logic [lruc_pkg::DATA_W-1:0]    hit_value,
  output logic [lruc_pkg::TIME_W-1:0]    remaining_life
);
  import lruc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_ELAPSE = 3'd2;
  localparam logic [2:0] S_LIVE   = 3'd3;
  localparam logic [2:0] S_APPLY  = 3'd4;

  logic [2:0] state;

  // entry store
  logic [ENTRIES-1:0] entry_valid;
  logic [KEY_W-1:0]   stored_key      [ENTRIES];
  logic [DATA_W-1:0]  stored_value    [ENTRIES];
  logic [TIME_W-1:0]  stored_lifetime [ENTRIES];
  logic [TIME_W-1:0]  insert_time     [ENTRIES];
  logic [IDX_W-1:0]   recency_rank    [ENTRIES];
  logic [CNT_W-1:0]   entry_count;
  logic [CFG_W-1:0]   max_entries;

  // captured transaction
  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] val_r;
  logic [TIME_W-1:0] life_r;
  logic [TIME_W-1:0] now_r;

  // scan results
  logic [IDX_W-1:0]  idx;
  logic              found;
  logic [IDX_W-1:0]  fidx;
  logic              free_ok;
  logic [IDX_W-1:0]  free_idx;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] remain;
  logic              live;

  logic [CNT_W-1:0]  cap;
  logic [IDX_W-1:0]  cap_m1;
  logic              evict;
  logic              out_free;
  logic [IDX_W-1:0]  rf;

  logic [TIME_W-1:0] alu_a;
  logic [TIME_W-1:0] alu_b;
  lruc_sub_t         alu_res;

  always_comb begin
    if (max_entries == '0) begin
      cap = CNT_W'(1);
    end else if (CNT_W'(max_entries) > CNT_W'(ENTRIES)) begin
      cap = CNT_W'(ENTRIES);
    end else begin
      cap = CNT_W'(max_entries);
    end
  end

  assign cap_m1   = IDX_W'(cap - CNT_W'(1));
  assign evict    = (entry_count >= cap);
  assign out_free = !out_valid || !out_stall;
  assign rf       = recency_rank[fidx];
  assign in_stall = (state != S_IDLE);

  // elapsed = now - inserted; then lifetime - elapsed gives remaining life and expiry
  always_comb begin
    if (state == S_ELAPSE) begin
      alu_a = now_r;
      alu_b = insert_time[fidx];
    end else begin
      alu_a = stored_lifetime[fidx];
      alu_b = elapsed;
    end
  end

  lruc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
            idx   <= '0;
          end
        end
        S_SCAN: begin
          idx <= idx + IDX_W'(1);
          if (idx == IDX_W'(ENTRIES - 1)) begin
            state <= S_ELAPSE;
          end
        end
        S_ELAPSE: state <= S_LIVE;
        S_LIVE:   state <= S_APPLY;
        S_APPLY: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_r    <= opcode;
      key_r   <= lookup_key;
      val_r   <= data_value;
      life_r  <= lifetime;
      now_r   <= now_time;
      found   <= 1'b0;
      fidx    <= '0;
      free_ok <= 1'b0;
      free_idx <= '0;
    end
    if (state == S_SCAN) begin
      if (!found && entry_valid[idx] && stored_key[idx] == key_r) begin
        found <= 1'b1;
        fidx  <= idx;
      end
      // first slot that is free, or becomes free through eviction
      if (!free_ok &&
          (!entry_valid[idx] || (evict && recency_rank[idx] >= cap_m1))) begin
        free_ok  <= 1'b1;
        free_idx <= idx;
      end
    end
    if (state == S_ELAPSE) begin
      elapsed <= alu_res.diff;
    end
    if (state == S_LIVE) begin
      remain <= alu_res.diff;
      live   <= !alu_res.borrow && (alu_res.diff != '0);
    end
  end

  // entry store update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
      max_entries <= CFG_W'(ENTRIES);
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_entries <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_APPLY && out_free) begin
        out_valid      <= 1'b1;
        hit_value      <= '0;
        remaining_life <= '0;
        if (op_r == OP_LOOKUP) begin
          if (!found) begin
            status <= ST_MISS;
          end else if (!live) begin
            status <= ST_EXPIRED;
            entry_valid[fidx] <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
              if (entry_valid[i] && recency_rank[i] > rf) begin
                recency_rank[i] <= recency_rank[i] - IDX_W'(1);
              end
            end
            entry_count <= entry_count - CNT_W'(1);
          end else begin
            status         <= ST_HIT;
            hit_value      <= stored_value[fidx];
            remaining_life <= remain;
            for (int i = 0; i < ENTRIES; i++) begin
              if (entry_valid[i] && recency_rank[i] < rf) begin
                recency_rank[i] <= recency_rank[i] + IDX_W'(1);
              end
            end
            recency_rank[fidx] <= '0;
          end
        end else if (found) begin
          status <= live ? ST_REFRESHED : ST_INSERTED;
          if (!live) begin
            stored_value[fidx]    <= val_r;
            stored_lifetime[fidx] <= life_r;
            insert_time[fidx]     <= now_r;
          end
          for (int i = 0; i < ENTRIES; i++) begin
            if (entry_valid[i] && recency_rank[i] < rf) begin
              recency_rank[i] <= recency_rank[i] + IDX_W'(1);
            end
          end
          recency_rank[fidx] <= '0;
        end else begin
          status <= evict ? ST_EVICTED : ST_INSERTED;
          // evicting down to cap-1 drops every entry ranked cap-1 or older
          for (int i = 0; i < ENTRIES; i++) begin
            if (entry_valid[i]) begin
              if (evict && recency_rank[i] >= cap_m1) begin
                entry_valid[i] <= 1'b0;
              end else begin
                recency_rank[i] <= recency_rank[i] + IDX_W'(1);
              end
            end
          end
          if (free_ok) begin
            entry_valid[free_idx]     <= 1'b1;
            recency_rank[free_idx]    <= '0;
            stored_key[free_idx]      <= key_r;
            stored_value[free_idx]    <= val_r;
            stored_lifetime[free_idx] <= life_r;
            insert_time[free_idx]     <= now_r;
            entry_count <= (evict ? cap - CNT_W'(1) : entry_count) + CNT_W'(1);
          end
        end
      end
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(entry_count))
    else $error("entry count disagrees with valid entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(ENTRIES))
    else $error("entry count above capacity");

  a_result_follows_apply: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && out_free) |=> (out_valid && state == S_IDLE))
    else $error("update step did not produce a result");

  a_insert_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && op_r == OP_INSERT && !found) |-> free_ok)
    else $error("insert found no free slot");

endmodule
